/* hdl/htwd_pkg.sv */
// package for the huffman tree walk decoder
// request types for the input and result channels and fixed field widths
// no dependencies
package htwd_pkg;

  localparam int NODE_IDX_W = 9;
  localparam int SYM_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 40;
  localparam int BIT_CNT_W  = $clog2(BYTE_W + 1);

  localparam logic MODE_NODE = 1'b0;
  localparam logic MODE_BYTE = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [NODE_IDX_W-1:0] node_index;
    logic [NODE_IDX_W-1:0] left_index;
    logic [NODE_IDX_W-1:0] right_index;
    logic                  leaf_flag;
    logic [SYM_W-1:0]      leaf_symbol;
    logic [BYTE_W-1:0]     coded_byte;
  } htwd_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic             last_of_run;
    logic             stream_done;
  } htwd_out_t;

endpackage

/* hdl/huffman_tree_walk_decoder_top.sv */
// huffman tree walk decoder, top level
// node table memory, bit walker, symbol hold stage and result register
// depends on htwd_pkg
//
// Usage: the input channel carries two kinds of request. A node request
// (mode 0) writes one entry of the node table. A byte request (mode 1) is
// walked most significant bit first, one bit per cycle while the walk is
// not paused: each bit reads the child entry from the single-port node
// table, whose read data arrives in the next cycle. A byte passes through
// its bit steps, a step for the last read and a step to close the byte;
// requests are taken only while idle, so a new byte waits until the last
// one is through. A byte that arrives after the symbol total is reached,
// or with the total at zero, is taken and dropped without a walk. The
// walk ends early on the symbol that completes the total. Each symbol
// waits in a hold stage until the next one or the end of the byte decides
// its last flag. The result register keeps its request while the
// receiver stalls; a leaf found with the hold stage also full then pauses
// the walk. Reset returns the walk to the root and clears the symbol count
// and total; the node table keeps no reset value and must be written
// before use. Write the total only while idle.
module huffman_tree_walk_decoder_top
  import htwd_pkg::*;
#(
  parameter int MAX_NODES   = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  htwd_in_t           in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output htwd_out_t          out_req_o,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i
);

  localparam int AW = $clog2(MAX_NODES);

  typedef struct packed {
    logic [NODE_IDX_W-1:0]  left;
    logic [NODE_IDX_W-1:0]  right;
    logic                   leaf;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  node_t mem [MAX_NODES];
  node_t rdata_q;

  state_e                 state_q, state_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          rd_addr_q, rd_addr_d;
  logic [AW-1:0]          walk_q, walk_d;
  node_t                  entry_q, entry_d;
  node_t                  root_q, root_d;
  logic [BYTE_W-1:0]      byte_q, byte_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic                   hold_v_q, hold_v_d;
  logic [SYMBOL_BITS-1:0] hold_sym_q, hold_sym_d;
  logic                   hold_done_q, hold_done_d;
  logic [COUNT_W-1:0]     cnt_q, cnt_d;
  logic [COUNT_W-1:0]     total_q, total_d;
  logic                   out_valid_q, out_valid_d;
  htwd_out_t              out_req_q, out_req_d;

  logic                   mem_we, mem_re;
  logic [AW-1:0]          wr_addr;
  node_t                  wr_node;
  node_t                  eff_node;
  logic [AW-1:0]          eff_walk;
  logic                   stop;
  logic                   stall;
  logic                   out_free;
  logic                   done_if_leaf;
  logic [COUNT_W-1:0]     cnt_inc;
  logic [NODE_IDX_W-1:0]  child;
  logic                   idx_ok;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  assign out_free     = !out_valid_q || out_ready_i;
  assign cnt_inc      = cnt_q + COUNT_W'(1);
  assign done_if_leaf = (cnt_inc == total_q);
  assign idx_ok       = 32'(in_req_i.node_index) < 32'(MAX_NODES);
  assign wr_addr      = AW'(in_req_i.node_index);

  always_comb begin
    wr_node.left  = in_req_i.left_index;
    wr_node.right = in_req_i.right_index;
    wr_node.leaf  = in_req_i.leaf_flag;
    wr_node.sym   = SYMBOL_BITS'(in_req_i.leaf_symbol);
  end

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    rd_addr_d   = rd_addr_q;
    walk_d      = walk_q;
    entry_d     = entry_q;
    root_d      = root_q;
    byte_d      = byte_q;
    bit_cnt_d   = bit_cnt_q;
    hold_v_d    = hold_v_q;
    hold_sym_d  = hold_sym_q;
    hold_done_d = hold_done_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_req_d   = out_req_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    eff_node    = entry_q;
    eff_walk    = walk_q;
    stop        = 1'b0;
    stall       = 1'b0;
    child       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      total_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.mode == MODE_NODE) begin
            if (idx_ok) begin
              mem_we = 1'b1;
              if (in_req_i.node_index == '0) begin
                root_d = wr_node;
              end
              if (wr_addr == walk_q) begin
                entry_d = wr_node;
              end
            end
          end else if (cnt_q < total_q) begin
            byte_d    = in_req_i.coded_byte;
            bit_cnt_d = '0;
            state_d   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        stall = pend_q && rdata_q.leaf && hold_v_q && !out_free;
        if (!stall) begin
          if (pend_q) begin
            if (rdata_q.leaf) begin
              eff_node    = root_q;
              eff_walk    = '0;
              stop        = done_if_leaf;
              cnt_d       = cnt_inc;
              if (hold_v_q) begin
                out_valid_d           = 1'b1;
                out_req_d.out_symbol  = SYM_W'(hold_sym_q);
                out_req_d.last_of_run = 1'b0;
                out_req_d.stream_done = hold_done_q;
              end
              hold_v_d    = 1'b1;
              hold_sym_d  = rdata_q.sym;
              hold_done_d = done_if_leaf;
            end else begin
              eff_node = rdata_q;
              eff_walk = rd_addr_q;
            end
          end
          pend_d  = 1'b0;
          entry_d = eff_node;
          walk_d  = eff_walk;
          if (!stop && (bit_cnt_q != BIT_CNT_W'(BYTE_W))) begin
            bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
            byte_d    = byte_q << 1;
            child     = byte_q[BYTE_W-1] ? eff_node.right : eff_node.left;
            if (32'(child) < 32'(MAX_NODES)) begin
              mem_re    = 1'b1;
              rd_addr_d = AW'(child);
              pend_d    = 1'b1;
            end else begin
              entry_d = root_q;
              walk_d  = '0;
            end
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d           = 1'b1;
          out_req_d.out_symbol  = SYM_W'(hold_sym_q);
          out_req_d.last_of_run = 1'b1;
          out_req_d.stream_done = hold_done_q;
          hold_v_d              = 1'b0;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      walk_q      <= '0;
      bit_cnt_q   <= '0;
      hold_v_q    <= 1'b0;
      cnt_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      walk_q      <= walk_d;
      bit_cnt_q   <= bit_cnt_d;
      hold_v_q    <= hold_v_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q   <= rd_addr_d;
    entry_q     <= entry_d;
    root_q      <= root_d;
    byte_q      <= byte_d;
    hold_sym_q  <= hold_sym_d;
    hold_done_q <= hold_done_d;
    out_req_q   <= out_req_d;
  end

  // node table, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_node;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr_d];
    end
  end

endmodule

/* hdl/htwd_checker.sv */
// port-level checks for the huffman tree walk decoder
// attached to huffman_tree_walk_decoder_top by the bind below
// depends on htwd_pkg
module htwd_checker
  import htwd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input htwd_in_t  in_req_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input htwd_out_t out_req_o
);

  // stalled result request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result request changed while stalled");

  // the symbol that completes the stream ends its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.stream_done |-> out_req_o.last_of_run)
    else $error("stream done without last of run");

  // the input stays ready after a node write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.mode == MODE_NODE) |=> in_ready_o)
    else $error("not ready after node write");

endmodule

bind huffman_tree_walk_decoder_top htwd_checker u_htwd_checker (.*);
